// ----- hdl/gav_pkg.sv -----
// gav_pkg: shared types and constants for the gas alarm vote and alert block.
// Used by gav_vote and gas_alarm_vote_and_alert_top; depends on nothing.
`default_nettype none

package gav_pkg;

  typedef enum logic [1:0] {
    KIND_ALERT  = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_STATUS = 2'd2
  } msg_kind_t;

  typedef enum logic [2:0] {
    REG_CO_TRIP       = 3'd0,
    REG_LPG_TRIP      = 3'd1,
    REG_CO_CLEAR      = 3'd2,
    REG_LPG_CLEAR     = 3'd3,
    REG_ALERT_GAP     = 3'd4,
    REG_STATUS_PERIOD = 3'd5,
    REG_SAMPLE_PERIOD = 3'd6,
    REG_WARMUP        = 3'd7
  } cfg_reg_t;

  localparam int CFG_IDX_W = 3;
  localparam int PPM_W     = 16;
  localparam int MS_W      = 32;
  localparam int SEQ_W     = 32;
  localparam int UP_W      = 23;

  localparam logic [PPM_W-1:0] RST_CO_TRIP       = 16'd50;
  localparam logic [PPM_W-1:0] RST_LPG_TRIP      = 16'd1000;
  localparam logic [PPM_W-1:0] RST_CO_CLEAR      = 16'd35;
  localparam logic [PPM_W-1:0] RST_LPG_CLEAR     = 16'd700;
  localparam logic [MS_W-1:0]  RST_ALERT_GAP     = 32'd10000;
  localparam logic [MS_W-1:0]  RST_STATUS_PERIOD = 32'd5000;
  localparam logic [MS_W-1:0]  RST_SAMPLE_PERIOD = 32'd500;
  localparam logic [PPM_W-1:0] RST_WARMUP        = 16'd120;

  // ms -> s: (n * magic) >> 38 is exact for any 32-bit n
  localparam logic [28:0] DIV1000_MAGIC = 29'd274877907;
  localparam int          DIV1000_SHIFT = 38;
  localparam int          DIV_PROD_W    = MS_W + 29;

  typedef struct packed {
    logic push;
    logic co_vote;
    logic lpg_vote;
  } vote_req_t;

  typedef struct packed {
    msg_kind_t        kind;
    logic [1:0]       mask;
    logic [PPM_W-1:0] co;
    logic [PPM_W-1:0] lpg;
    logic [SEQ_W-1:0] seq;
    logic [UP_W-1:0]  uptime;
    logic             last;
  } msg_rec_t;

endpackage

`default_nettype wire

// ----- hdl/gav_vote.sv -----
// gav_vote: per-gas vote windows, fill tracking and trip mask.
// Depends on gav_pkg (vote_req_t).
`default_nettype none

module gav_vote #(
  parameter int WINDOW_LEN    = 3,
  parameter int VOTES_TO_TRIP = 2
) (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire gav_pkg::vote_req_t req,
  output logic [1:0]               trip_mask
);
  import gav_pkg::*;

  localparam int PW    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CNT_W = $clog2(WINDOW_LEN + 1);

  logic [WINDOW_LEN-1:0] co_votes_r, co_votes_nxt;
  logic [WINDOW_LEN-1:0] lpg_votes_r, lpg_votes_nxt;
  logic [PW-1:0]         pos_r, pos_nxt;
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic [CNT_W-1:0]      co_cnt, lpg_cnt;
  logic                  full;

  always_comb begin
    co_votes_nxt         = co_votes_r;
    lpg_votes_nxt        = lpg_votes_r;
    co_votes_nxt[pos_r]  = req.co_vote;
    lpg_votes_nxt[pos_r] = req.lpg_vote;
    pos_nxt  = (pos_r == PW'(WINDOW_LEN - 1)) ? '0 : pos_r + PW'(1);
    fill_nxt = (fill_r == CNT_W'(WINDOW_LEN)) ? fill_r : fill_r + CNT_W'(1);
    full     = (fill_nxt == CNT_W'(WINDOW_LEN));
    co_cnt   = '0;
    lpg_cnt  = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      co_cnt  = co_cnt + CNT_W'(co_votes_nxt[i]);
      lpg_cnt = lpg_cnt + CNT_W'(lpg_votes_nxt[i]);
    end
    trip_mask[0] = full && (32'(co_cnt) >= 32'(VOTES_TO_TRIP));
    trip_mask[1] = full && (32'(lpg_cnt) >= 32'(VOTES_TO_TRIP));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      co_votes_r  <= '0;
      lpg_votes_r <= '0;
      pos_r       <= '0;
      fill_r      <= '0;
    end else if (req.push) begin
      co_votes_r  <= co_votes_nxt;
      lpg_votes_r <= lpg_votes_nxt;
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/gas_alarm_vote_and_alert_top.sv -----
// gas_alarm_vote_and_alert_top: sampling, warm-up, alert/clear/status logic.
// Depends on gav_pkg and gav_vote.
//
// Usage:
//   Input beats (in_valid/in_stall) carry now_ms and the CO/LPG readings of
//   one polling pass. Each beat yields zero, one or two result beats on the
//   out_ channel: an alert or clear first, then a status heartbeat;
//   out_last_of_run marks the final result of a beat.
//   A beat is registered in the input register on acceptance; it is
//   evaluated from there and its first result goes to the output register.
//   Throughput: one input beat per cycle when it makes at most one result
//   and the output does not stall; a beat that makes two results holds the
//   next beat back while the single output register drains one result per
//   cycle (the second waits in a one-entry holding register).
//   A stall on the output holds the result register and pauses evaluation,
//   as does an occupied holding register; in_stall rises while a beat waits.
//   Config writes (cfg_valid/cfg_ready, cfg_ready always high) are to be
//   made only while the block is idle; the block does not enforce this.
//   Reset (rst_n low, synchronous) restores register defaults and clears
//   all timers, counters, vote windows and pending results.
`default_nettype none

module gas_alarm_vote_and_alert_top #(
  parameter int WINDOW_LEN    = 3,
  parameter int VOTES_TO_TRIP = 2
) (
  input  wire  logic                           clk,
  input  wire  logic                           rst_n,
  input  wire  logic                           in_valid,
  output logic                                 in_stall,
  input  wire  logic [gav_pkg::MS_W-1:0]       in_now_ms,
  input  wire  logic [gav_pkg::PPM_W-1:0]      in_co_reading_ppm,
  input  wire  logic [gav_pkg::PPM_W-1:0]      in_lpg_reading_ppm,
  output logic                                 out_valid,
  input  wire  logic                           out_stall,
  output logic [1:0]                           out_msg_kind,
  output logic [1:0]                           out_trip_mask,
  output logic [gav_pkg::PPM_W-1:0]            out_co_level,
  output logic [gav_pkg::PPM_W-1:0]            out_lpg_level,
  output logic [gav_pkg::SEQ_W-1:0]            out_sequence_res,
  output logic [gav_pkg::UP_W-1:0]             out_uptime_sec,
  output logic                                 out_last_of_run,
  input  wire  logic                           cfg_valid,
  output logic                                 cfg_ready,
  input  wire  logic [gav_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  logic [gav_pkg::MS_W-1:0]       cfg_data
);
  import gav_pkg::*;

  // configuration
  logic [PPM_W-1:0] co_trip_r, lpg_trip_r, co_clear_r, lpg_clear_r, warmup_r;
  logic [MS_W-1:0]  alert_gap_r, status_period_r, sample_period_r;

  // input register
  logic             s1_valid_r;
  logic [MS_W-1:0]  s1_now_r;
  logic [PPM_W-1:0] s1_co_r, s1_lpg_r;
  logic [UP_W-1:0]  s1_up_r;
  logic [DIV_PROD_W-1:0] div_prod;

  // block state
  logic [MS_W-1:0]  last_sample_r, last_status_r, last_alert_r;
  logic [SEQ_W-1:0] msg_cnt_r, msg_cnt_nxt;
  logic             warmed_r, warmed_nxt;
  logic             alarm_r, alarm_nxt;
  logic [1:0]       prev_mask_r, prev_mask_nxt;
  logic [PPM_W-1:0] held_co_r, held_lpg_r, held_co_nxt, held_lpg_nxt;

  // output side
  msg_rec_t out_rec_r, out_rec_nxt, pend_rec_r, pend_rec_nxt;
  logic     out_valid_r, out_valid_nxt, pend_valid_r, pend_valid_nxt;

  // evaluation
  logic       out_free, can_proc, proceed, accept_in;
  logic       sample_due, eval, status, alert, clear, first_ev;
  vote_req_t  vote_req;
  logic [1:0] mask;
  msg_rec_t   rec_a, rec_s, first_rec;
  logic       first_valid, second_valid;

  gav_vote #(
    .WINDOW_LEN    (WINDOW_LEN),
    .VOTES_TO_TRIP (VOTES_TO_TRIP)
  ) u_vote (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (vote_req),
    .trip_mask (mask)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      co_trip_r       <= RST_CO_TRIP;
      lpg_trip_r      <= RST_LPG_TRIP;
      co_clear_r      <= RST_CO_CLEAR;
      lpg_clear_r     <= RST_LPG_CLEAR;
      alert_gap_r     <= RST_ALERT_GAP;
      status_period_r <= RST_STATUS_PERIOD;
      sample_period_r <= RST_SAMPLE_PERIOD;
      warmup_r        <= RST_WARMUP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_CO_TRIP:       co_trip_r       <= cfg_data[PPM_W-1:0];
        REG_LPG_TRIP:      lpg_trip_r      <= cfg_data[PPM_W-1:0];
        REG_CO_CLEAR:      co_clear_r      <= cfg_data[PPM_W-1:0];
        REG_LPG_CLEAR:     lpg_clear_r     <= cfg_data[PPM_W-1:0];
        REG_ALERT_GAP:     alert_gap_r     <= cfg_data;
        REG_STATUS_PERIOD: status_period_r <= cfg_data;
        REG_SAMPLE_PERIOD: sample_period_r <= cfg_data;
        REG_WARMUP:        warmup_r        <= cfg_data[PPM_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign can_proc  = !pend_valid_r && out_free;
  assign proceed   = s1_valid_r && can_proc;
  assign in_stall  = s1_valid_r && !can_proc;
  assign accept_in = in_valid && !in_stall;

  assign div_prod = DIV_PROD_W'(in_now_ms) * DIV_PROD_W'(DIV1000_MAGIC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept_in) begin
      s1_valid_r <= 1'b1;
    end else if (proceed) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      s1_now_r <= in_now_ms;
      s1_co_r  <= in_co_reading_ppm;
      s1_lpg_r <= in_lpg_reading_ppm;
      s1_up_r  <= div_prod[DIV1000_SHIFT +: UP_W];
    end
  end

  // one pass of the polling loop
  always_comb begin
    sample_due = (s1_now_r - last_sample_r) >= sample_period_r;
    eval       = sample_due && warmed_r;
    warmed_nxt = warmed_r || (sample_due && (s1_up_r >= UP_W'(warmup_r)));

    vote_req.push     = proceed && eval;
    vote_req.co_vote  = s1_co_r >= co_trip_r;
    vote_req.lpg_vote = s1_lpg_r >= lpg_trip_r;

    alert = eval && (mask != 2'b00) &&
            ((mask != prev_mask_r) || ((s1_now_r - last_alert_r) >= alert_gap_r));
    clear = eval && (mask == 2'b00) && alarm_r &&
            (s1_co_r < co_clear_r) && (s1_lpg_r < lpg_clear_r);

    alarm_nxt     = alarm_r;
    prev_mask_nxt = prev_mask_r;
    if (eval && (mask != 2'b00)) begin
      alarm_nxt     = 1'b1;
      prev_mask_nxt = mask;
    end else if (clear) begin
      alarm_nxt     = 1'b0;
      prev_mask_nxt = 2'b00;
    end

    held_co_nxt  = eval ? s1_co_r : held_co_r;
    held_lpg_nxt = eval ? s1_lpg_r : held_lpg_r;

    status   = warmed_nxt && ((s1_now_r - last_status_r) >= status_period_r);
    first_ev = alert || clear;

    rec_a.kind   = alert ? KIND_ALERT : KIND_CLEAR;
    rec_a.mask   = alert ? mask : 2'b00;
    rec_a.co     = held_co_nxt;
    rec_a.lpg    = held_lpg_nxt;
    rec_a.seq    = msg_cnt_r + SEQ_W'(1);
    rec_a.uptime = s1_up_r;
    rec_a.last   = !status;

    rec_s.kind   = KIND_STATUS;
    rec_s.mask   = alarm_nxt ? prev_mask_nxt : 2'b00;
    rec_s.co     = held_co_nxt;
    rec_s.lpg    = held_lpg_nxt;
    rec_s.seq    = msg_cnt_r + (first_ev ? SEQ_W'(2) : SEQ_W'(1));
    rec_s.uptime = s1_up_r;
    rec_s.last   = 1'b1;

    first_rec    = first_ev ? rec_a : rec_s;
    first_valid  = first_ev || status;
    second_valid = first_ev && status;
    msg_cnt_nxt  = msg_cnt_r + SEQ_W'(first_ev) + SEQ_W'(status);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sample_r <= '0;
      last_status_r <= '0;
      last_alert_r  <= '0;
      msg_cnt_r     <= '0;
      warmed_r      <= 1'b0;
      alarm_r       <= 1'b0;
      prev_mask_r   <= 2'b00;
      held_co_r     <= '0;
      held_lpg_r    <= '0;
    end else if (proceed) begin
      if (sample_due) last_sample_r <= s1_now_r;
      if (status) last_status_r <= s1_now_r;
      if (alert) last_alert_r <= s1_now_r;
      msg_cnt_r   <= msg_cnt_nxt;
      warmed_r    <= warmed_nxt;
      alarm_r     <= alarm_nxt;
      prev_mask_r <= prev_mask_nxt;
      held_co_r   <= held_co_nxt;
      held_lpg_r  <= held_lpg_nxt;
    end
  end

  // result register plus one holding entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_rec_nxt    = out_rec_r;
    pend_valid_nxt = pend_valid_r;
    pend_rec_nxt   = pend_rec_r;
    if (pend_valid_r && out_free) begin
      out_valid_nxt  = 1'b1;
      out_rec_nxt    = pend_rec_r;
      pend_valid_nxt = 1'b0;
    end else if (proceed) begin
      out_valid_nxt  = first_valid;
      out_rec_nxt    = first_rec;
      pend_valid_nxt = second_valid;
      pend_rec_nxt   = rec_s;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rec_r  <= out_rec_nxt;
    pend_rec_r <= pend_rec_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_msg_kind     = out_rec_r.kind;
  assign out_trip_mask    = out_rec_r.mask;
  assign out_co_level     = out_rec_r.co;
  assign out_lpg_level    = out_rec_r.lpg;
  assign out_sequence_res = out_rec_r.seq;
  assign out_uptime_sec   = out_rec_r.uptime;
  assign out_last_of_run  = out_rec_r.last;

  // checks
  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r)
    else $error("holding entry occupied while result register empty");

  a_pend_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (pend_rec_r.kind == KIND_STATUS) && pend_rec_r.last)
    else $error("holding entry is not the closing status beat");

  a_idle_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
    !alarm_r |-> (prev_mask_r == 2'b00))
    else $error("trip mask held without an active alarm");

  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !out_rec_r.last) |=>
      out_valid_r && (out_rec_r.seq == $past(out_rec_r.seq) + SEQ_W'(1)))
    else $error("second beat of a run does not follow the first");

endmodule

`default_nettype wire
